// File: sv/ps2cq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 command queue package
// Shared types and constants of the PS/2 host command queue.
// ----------------------------------------------------------------------------
package ps2cq_pkg;

  localparam logic [7:0] ACK_BYTE    = 8'hFA;
  localparam logic [7:0] RESEND_BYTE = 8'hFE;
  localparam logic [3:0] RETRY_RESET = 4'd3;
  localparam int unsigned IN_FIELDS  = 4;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned S_TDATA_W  = 48;
  localparam int unsigned M_TDATA_W  = 24;
  localparam int unsigned RES_W      = 20;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_RECEIVE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic       queue_busy;
    logic       enqueue_accepted;
    logic [7:0] forward_byte;
    logic       forward_valid;
    logic [7:0] send_byte;
    logic       send_valid;
  } res_t;

endpackage
`default_nettype wire

// File: sv/ps2_command_queue_ack_retry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 host command queue with ACK and RESEND handling
// Queues commands of one to four bytes in a ring memory and sends them byte
// by byte; with one active, ACK advances and RESEND repeats; other bytes pass on.
// ----------------------------------------------------------------------------
// An enqueue or a passed-on byte is registered as a result and then loaded into
// the output register; an ACK or RESEND first reads its ring row, and a retire
// that starts the next command reads the next row, both through the single read port.
// New input is taken only in the idle state, so the next item waits until the
// last result has gone into the output register, which back-pressure can hold.
// Reset clears pointers, flags and counters and sets the retry limit to 3;
// ring contents are not cleared, but head equals tail, so the ring reads empty.
module ps2_command_queue_ack_retry #(
  parameter int unsigned QUEUE_SLOTS = 8,
  parameter int unsigned MAX_BYTES   = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [3:0]                       cfg_data_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // cmd_byte0, cmd_byte1, cmd_byte2, cmd_byte3, cmd_length, rx_byte, zero fill
  input  wire logic [ps2cq_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // action
  input  wire logic [0:0]                       s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // send_valid, send_byte, forward_valid, forward_byte, enqueue_accepted,
  // queue_busy, zero fill
  output logic      [ps2cq_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  import ps2cq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_SLOTS);
  localparam int unsigned PW    = $clog2(MAX_BYTES + 1);
  localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned CMPW  = (PW > LEN_W) ? PW : LEN_W;
  localparam int unsigned ROW_W = MAX_BYTES * 8 + LEN_W;

  state_e state_q, state_d;

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [PTR_W-1:0] head_inc, tail_inc;
  logic             busy_q, busy_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [3:0]       retries_q, retries_d;
  logic [3:0]       limit_q;
  logic             is_ack_q, is_ack_d;
  res_t             res_q, res_d;
  res_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic                         in_xfer, out_load;
  logic                         act;
  logic [IN_FIELDS-1:0][7:0]    cmd;
  logic [LEN_W-1:0]             cmd_len;
  logic [7:0]                   rx_byte;
  logic                         len_ok, full, rx_ctrl;
  logic                         go_exec, go_start;
  logic [MAX_BYTES-1:0][7:0]    wr_bytes;
  logic [MAX_BYTES-1:0][7:0]    rd_bytes;
  logic [LEN_W-1:0]             rd_len;
  logic [ROW_W-1:0]             ram_wdata, ram_rdata;
  logic                         ram_we, ram_re;
  logic [PTR_W-1:0]             ram_raddr;
  logic [PW-1:0]                last_pos;
  logic [IDX_W-1:0]             rd_idx;

  assign act     = s_axis_tuser_i[0];
  assign cmd     = s_axis_tdata_i[8*IN_FIELDS-1:0];
  assign cmd_len = s_axis_tdata_i[8*IN_FIELDS +: LEN_W];
  assign rx_byte = s_axis_tdata_i[8*IN_FIELDS+LEN_W +: 8];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - RES_W)'(0), out_q};

  assign head_inc = (head_q == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : tail_q + 1'b1;
  assign full     = (tail_inc == head_q);
  assign len_ok   = (cmd_len != '0) && (4'(cmd_len) <= 4'(MAX_BYTES))
                    && (4'(cmd_len) <= 4'(IN_FIELDS));
  assign rx_ctrl  = (rx_byte == ACK_BYTE) || (rx_byte == RESEND_BYTE);

  for (genvar i = 0; i < MAX_BYTES; i++) begin : g_wr
    if (i < IN_FIELDS) begin : g_field
      assign wr_bytes[i] = (4'(i) < 4'(cmd_len)) ? cmd[i] : 8'h00;
    end else begin : g_zero
      assign wr_bytes[i] = 8'h00;
    end
  end

  assign ram_wdata = {wr_bytes, cmd_len};
  assign rd_len    = ram_rdata[LEN_W-1:0];
  assign rd_bytes  = ram_rdata[ROW_W-1:LEN_W];
  assign last_pos  = (pos_q == '0) ? '0 : pos_q - 1'b1;
  assign rd_idx    = is_ack_q ? pos_q[IDX_W-1:0] : last_pos[IDX_W-1:0];

  ps2cq_ram #(
    .WIDTH(ROW_W),
    .DEPTH(QUEUE_SLOTS)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Datapath and ring updates.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    busy_d      = busy_q;
    pos_d       = pos_q;
    retries_d   = retries_q;
    is_ack_d    = is_ack_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = head_q;
    go_exec     = 1'b0;
    go_start    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_d = '0;
          if (act == ACT_ENQUEUE) begin
            if (len_ok && !full) begin
              ram_we                 = 1'b1;
              tail_d                 = tail_inc;
              res_d.enqueue_accepted = 1'b1;
              if (!busy_q) begin
                busy_d           = 1'b1;
                pos_d            = PW'(1);
                retries_d        = limit_q;
                res_d.send_valid = 1'b1;
                res_d.send_byte  = cmd[0];
              end
            end
            res_d.queue_busy = busy_q || (len_ok && !full);
          end else if (busy_q && rx_ctrl) begin
            ram_re   = 1'b1;
            is_ack_d = (rx_byte == ACK_BYTE);
            go_exec  = 1'b1;
          end else begin
            res_d.forward_valid = 1'b1;
            res_d.forward_byte  = rx_byte;
            res_d.queue_busy    = busy_q;
          end
        end
      end
      S_EXEC: begin
        res_d.queue_busy = 1'b1;
        if (is_ack_q && (CMPW'(pos_q) < CMPW'(rd_len))) begin
          pos_d            = pos_q + 1'b1;
          res_d.send_valid = 1'b1;
          res_d.send_byte  = rd_bytes[rd_idx];
        end else if (!is_ack_q && (retries_q != '0)) begin
          retries_d        = retries_q - 1'b1;
          res_d.send_valid = 1'b1;
          res_d.send_byte  = rd_bytes[rd_idx];
        end else begin
          head_d = head_inc;
          if (head_inc == tail_q) begin
            busy_d           = 1'b0;
            pos_d            = '0;
            res_d.queue_busy = 1'b0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head_inc;
            go_start  = 1'b1;
          end
        end
      end
      S_START: begin
        pos_d            = PW'(1);
        retries_d        = limit_q;
        res_d.send_valid = 1'b1;
        res_d.send_byte  = rd_bytes[0];
        res_d.queue_busy = 1'b1;
      end
      S_EMIT: begin
        if (out_load) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = go_exec ? S_EXEC : S_EMIT;
        end
      end
      S_EXEC: begin
        state_d = go_start ? S_START : S_EMIT;
      end
      S_START: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      busy_q      <= 1'b0;
      pos_q       <= '0;
      retries_q   <= '0;
      limit_q     <= RETRY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      retries_q   <= retries_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    is_ack_q <= is_ack_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  a_busy_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (head_q != tail_q))
    else $error("active command with an empty ring");

  a_idle_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (pos_q == '0))
    else $error("send position not cleared while idle");

  a_start_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START) |-> $past(state_q == S_EXEC))
    else $error("next command started without a retire or drop");

  a_exec_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> busy_q)
    else $error("reply handled with no active command");

endmodule
`default_nettype wire

// File: sv/ps2cq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ps2cq_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_ps2_command_queue_ack_retry.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench for the PS/2 host command queue with ACK and RESEND handling
// A directed table covers idle forwarding, bad lengths, ACK and RESEND
// sequences, retry exhaustion and a full ring. Random phases follow under
// several retry limits, with random stalls on both streams. Each result transfer is
// checked field by field against a typed row's expected result or a behavioral model.
// ----------------------------------------------------------------------------
module tb_ps2_command_queue_ack_retry;
  import ps2cq_pkg::*;

  localparam int unsigned SLOTS          = 8;
  localparam int unsigned PHASE_ITEMS    = 320;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] rx;
    logic [2:0] len;
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } cmd_fields_t;

  typedef struct {
    logic        act;
    cmd_fields_t f;
    bit          typed;
    res_t        want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [3:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tready = 1'b0;
  logic cfg_ready;
  logic s_tready;
  logic m_tvalid;
  logic [M_TDATA_W-1:0] m_tdata;

  bit   row_typed = 1'b0;
  res_t row_want = '0;

  logic [7:0] ring_bytes [SLOTS][4];
  logic [2:0] ring_len [SLOTS];
  logic [2:0] head_idx = '0;
  logic [2:0] tail_idx = '0;
  bit         cmd_busy = 1'b0;
  bit         wait_reply = 1'b0;
  logic [2:0] send_pos = '0;
  logic [3:0] retries = '0;
  logic [3:0] retry_cfg = RETRY_RESET;

  res_t host_response_q [$];
  dir_row_t dir_rows [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_count = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  res_t model_res;
  res_t got_res;
  res_t want_res_q;

  always #1 clk_i = ~clk_i;

  ps2_command_queue_ack_retry u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  function automatic int unsigned pick_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic res_t mk_res(bit sv, logic [7:0] sb, bit fv, logic [7:0] fb,
                                  bit acc, bit busy);
    res_t r;
    r.send_valid       = sv;
    r.send_byte        = sb;
    r.forward_valid    = fv;
    r.forward_byte     = fb;
    r.enqueue_accepted = acc;
    r.queue_busy       = busy;
    return r;
  endfunction

  // Starts the command at the head of the ring, or goes idle if it is empty.
  function automatic bit launch_head(output logic [7:0] tx);
    tx = '0;
    if (head_idx == tail_idx) begin
      cmd_busy   = 1'b0;
      wait_reply = 1'b0;
      send_pos   = '0;
      return 1'b0;
    end
    cmd_busy   = 1'b1;
    retries    = retry_cfg;
    tx         = ring_bytes[head_idx][0];
    send_pos   = 3'd1;
    wait_reply = 1'b1;
    return 1'b1;
  endfunction

  function automatic res_t predict_host_response(logic act, cmd_fields_t f);
    res_t r;
    logic [7:0] tx;
    logic [7:0] cmd_b [4];
    logic [2:0] nxt;
    bit handled;
    r = '0;
    tx = '0;
    handled = 1'b0;
    cmd_b = '{f.b0, f.b1, f.b2, f.b3};
    nxt = tail_idx + 3'd1;
    if (act == ACT_ENQUEUE) begin
      if (f.len >= 1 && f.len <= IN_FIELDS && nxt != head_idx) begin
        for (int i = 0; i < 4; i++) begin
          ring_bytes[tail_idx][i] = (i < f.len) ? cmd_b[i] : 8'h00;
        end
        ring_len[tail_idx] = f.len;
        tail_idx = nxt;
        r.enqueue_accepted = 1'b1;
        if (!cmd_busy) r.send_valid = launch_head(tx);
      end
    end else begin
      if (cmd_busy && wait_reply) begin
        if (f.rx == ACK_BYTE) begin
          handled = 1'b1;
          if (send_pos < ring_len[head_idx]) begin
            tx = ring_bytes[head_idx][send_pos[1:0]];
            send_pos = send_pos + 3'd1;
            r.send_valid = 1'b1;
          end else begin
            head_idx = head_idx + 3'd1;
            r.send_valid = launch_head(tx);
          end
        end else if (f.rx == RESEND_BYTE) begin
          handled = 1'b1;
          if (retries > 0) begin
            retries = retries - 4'd1;
            tx = ring_bytes[head_idx][(send_pos != 0) ? send_pos[1:0] - 2'd1 : 2'd0];
            r.send_valid = 1'b1;
          end else begin
            head_idx = head_idx + 3'd1;
            r.send_valid = launch_head(tx);
          end
        end
      end
      if (!handled) begin
        r.forward_valid = 1'b1;
        r.forward_byte  = f.rx;
      end
    end
    r.send_byte  = r.send_valid ? tx : 8'h00;
    r.queue_busy = cmd_busy;
    return r;
  endfunction

  function automatic void add_row(logic act, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                  logic [7:0] b3, logic [2:0] len, logic [7:0] rx,
                                  bit typed, res_t want);
    dir_row_t row;
    row.act   = act;
    row.f     = '{rx: rx, len: len, b3: b3, b2: b2, b1: b1, b0: b0};
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic drive_item(logic act, cmd_fields_t f, bit typed, res_t want);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= S_TDATA_W'(f);
    s_tuser   <= act;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (host_response_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_retry_limit(logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    retry_cfg = value;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        model_res = predict_host_response(s_tuser[0], cmd_fields_t'(s_tdata[42:0]));
        host_response_q.push_back(row_typed ? row_want : model_res);
      end
      if (m_tvalid && m_tready) begin
        got_res = res_t'(m_tdata[RES_W-1:0]);
        if (host_response_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got_res);
        end else begin
          want_res_q = host_response_q.pop_front();
          check_field("send_valid", want_res_q.send_valid, got_res.send_valid);
          check_field("send_byte", want_res_q.send_byte, got_res.send_byte);
          check_field("forward_valid", want_res_q.forward_valid, got_res.forward_valid);
          check_field("forward_byte", want_res_q.forward_byte, got_res.forward_byte);
          check_field("enqueue_accepted", want_res_q.enqueue_accepted,
                      got_res.enqueue_accepted);
          check_field("queue_busy", want_res_q.queue_busy, got_res.queue_busy);
        end
        rx_count++;
        if (rx_count % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_stall = pick_gap(rx_calm);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      m_tready <= (rx_stall == 0);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] limits [4];
    cmd_fields_t f;
    logic act;
    int unsigned enq_pct;
    int unsigned r;

    limits = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), 4'd1};

    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 8'h00, 1,
            mk_res(0, 8'h00, 1, 8'h00, 0, 0));
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, RESEND_BYTE, 1,
            mk_res(0, 8'h00, 1, RESEND_BYTE, 0, 0));
    add_row(ACT_ENQUEUE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd0, 8'hFF, 1, '0);
    add_row(ACT_ENQUEUE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd5, 8'h00, 1, '0);
    add_row(ACT_ENQUEUE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 8'hFF, 1, '0);
    add_row(ACT_ENQUEUE, 8'hFF, 8'h00, 8'hAA, 8'h55, 3'd4, 8'h00, 1,
            mk_res(1, 8'hFF, 0, 8'h00, 1, 1));
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 8'h12, 1,
            mk_res(0, 8'h00, 1, 8'h12, 0, 1));
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ACK_BYTE, 1,
            mk_res(1, 8'h00, 0, 8'h00, 0, 1));
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, RESEND_BYTE, 1,
            mk_res(1, 8'h00, 0, 8'h00, 0, 1));
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ACK_BYTE, 0, '0);
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ACK_BYTE, 0, '0);
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ACK_BYTE, 1, '0);
    add_row(ACT_ENQUEUE, 8'hED, 8'h11, 8'h22, 8'h33, 3'd1, 8'h00, 1,
            mk_res(1, 8'hED, 0, 8'h00, 1, 1));
    repeat (3) begin
      add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, RESEND_BYTE, 1,
              mk_res(1, 8'hED, 0, 8'h00, 0, 1));
    end
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, RESEND_BYTE, 1, '0);
    add_row(ACT_ENQUEUE, 8'hF3, 8'h0A, 8'h00, 8'h00, 3'd2, 8'h00, 1,
            mk_res(1, 8'hF3, 0, 8'h00, 1, 1));
    for (int i = 0; i < 6; i++) begin
      add_row(ACT_ENQUEUE, 8'(8'h20 + i), 8'(8'h40 + i), 8'(8'h80 + i), 8'h00, 3'd3, 8'h00,
              0, '0);
    end
    add_row(ACT_ENQUEUE, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 3'd3, 8'h00, 1,
            mk_res(0, 8'h00, 0, 8'h00, 0, 1));
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ACK_BYTE, 0, '0);
    add_row(ACT_RECEIVE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, ACK_BYTE, 0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].act, dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_retry_limit(limits[p]);
      enq_pct = $urandom_range(15, 45);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        f = cmd_fields_t'(43'({$urandom(), $urandom()}));
        r = $urandom_range(0, 99);
        act = (r < (cmd_busy ? enq_pct : 50)) ? ACT_ENQUEUE : ACT_RECEIVE;
        if (act == ACT_ENQUEUE) begin
          if ($urandom_range(0, 99) < 85) begin
            f.len = 3'($urandom_range(1, 4));
          end else begin
            r = $urandom_range(0, 3);
            f.len = (r == 0) ? 3'd0 : 3'(4 + r);
          end
        end else begin
          r = $urandom_range(0, 99);
          if (r < (cmd_busy ? 45 : 5)) begin
            f.rx = ACK_BYTE;
          end else if (r < (cmd_busy ? 70 : 10)) begin
            f.rx = RESEND_BYTE;
          end
        end
        drive_item(act, f, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
